/* src/frt_pkg.sv */
// Shared constants for the fragment reassembly tracker.
// Used by the top level.
package frt_pkg;

  localparam int SLOTS_DEF         = 16;
  localparam int MAX_FRAGMENTS_DEF = 64;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 16;

  localparam logic [2:0] STAT_STORED    = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_COMPLETE  = 3'd2;
  localparam logic [2:0] STAT_INVALID   = 3'd3;
  localparam logic [2:0] STAT_MISMATCH  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INFLIGHT  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYFRAME_MASK = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_EVICT
  } state_t;

  typedef struct packed {
    logic [63:0] frame_id;
    logic [5:0]  fragment_index;
    logic [6:0]  fragment_count;
    logic [15:0] frame_flags;
    logic [7:0]  codec_id;
    logic [63:0] display_time;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] done_frame;
    logic [63:0] done_time;
    logic        is_keyframe;
    logic [7:0]  done_codec;
  } result_t;

endpackage

/* src/frt_ifs.sv */
// Channel interfaces of the fragment reassembly tracker: fragment input,
// result output and configuration writes. Depends on nothing else.
interface frt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_id;
  logic [5:0]  fragment_index;
  logic [6:0]  fragment_count;
  logic [15:0] frame_flags;
  logic [7:0]  codec_id;
  logic [63:0] display_time;
  modport source (output valid, frame_id, fragment_index, fragment_count, frame_flags,
                  codec_id, display_time, input ready);
  modport sink (input valid, frame_id, fragment_index, fragment_count, frame_flags,
                codec_id, display_time, output ready);
endinterface

interface frt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] done_frame;
  logic [63:0] done_time;
  logic        is_keyframe;
  logic [7:0]  done_codec;
  modport source (output valid, status, done_frame, done_time, is_keyframe, done_codec,
                  input ready);
  modport sink (input valid, status, done_frame, done_time, is_keyframe, done_codec,
                output ready);
endinterface

interface frt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/frt_slot_mem.sv */
// Slot table memory: one write port and one read port with registered data.
// Depends on nothing else.
module frt_slot_mem #(
  parameter int Depth = 16,
  parameter int DataW = 8,
  parameter int AddrW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/frame_fragment_reassembly_tracker.sv */
// Top level of the fragment reassembly tracker.
// Depends on frt_pkg, frt_ifs and frt_slot_mem.
//
// Usage: fragment descriptors enter on in_ch, one result word per fragment
// leaves on out_ch, and cfg_ch writes max_inflight (index 0) and
// keyframe_mask (index 1). cfg_ch is always ready; write it only while idle.
// A fragment is handled in three phases: a search sweep reads every slot of
// the table memory once, the decide state updates the matched or allocated
// slot of a stored or completed fragment, and after such a fragment an
// eviction sweep reads every slot again if the highest frame id exceeds
// max_inflight. The result word is registered when the decide state fires.
// The next fragment is accepted only in the idle state, once the previous
// one has left its search, decide and eviction phases; the single read port
// of the slot memory makes each sweep read the slots one by one.
// The result is held in an output register, so the next fragment is taken
// while a result waits; a stalled receiver holds the block only in the
// decide state of the following fragment. Reset clears all slot valid
// flags, the highest id and loads max_inflight 8 and keyframe_mask 1.
module frame_fragment_reassembly_tracker
  import frt_pkg::*;
#(
  parameter int Slots        = SLOTS_DEF,
  parameter int MaxFragments = MAX_FRAGMENTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  frt_in_if.sink    in_ch,
  frt_out_if.source out_ch,
  frt_cfg_if.sink   cfg_ch
);

  localparam int SlotW = $clog2(Slots);
  localparam int CntW  = $clog2(Slots + 1);
  localparam logic [MaxFragments-1:0] PresOne = 1;

  typedef struct packed {
    logic [63:0]             frame;
    logic [6:0]              total;
    logic [15:0]             flags;
    logic [7:0]              codec;
    logic [63:0]             dtime;
    logic [MaxFragments-1:0] presence;
    logic [6:0]              received;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  state_t            state_r, state_nxt;
  item_t             item_r, item_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       highest_r, highest_nxt;
  logic [3:0]        max_inflight_r;
  logic [15:0]       keyframe_mask_r;
  logic [Slots-1:0]  valid_r, valid_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [SlotW-1:0]  pidx_r, pidx_nxt;
  logic              found_r, found_nxt;
  logic [SlotW-1:0]  hit_idx_r, hit_idx_nxt;
  entry_t            hit_r, hit_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SlotW-1:0]  free_idx_r, free_idx_nxt;
  logic              min_vld_r, min_vld_nxt;
  logic [63:0]       min_frame_r, min_frame_nxt;
  logic [SlotW-1:0]  min_idx_r, min_idx_nxt;

  logic              mem_we;
  logic [SlotW-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [EntryW-1:0] mem_rdata;
  entry_t            rd;
  logic              issue;
  logic              sweep_done;
  logic              decide_fire;
  logic              evict_go;
  logic              invalid;
  logic [63:0]       hi_id;
  logic [63:0]       cutoff;
  logic [SlotW-1:0]  dec_slot;
  entry_t            base;
  entry_t            upd;
  logic [MaxFragments-1:0] bitv;

  frt_slot_mem #(
    .Depth (Slots),
    .DataW (EntryW),
    .AddrW (SlotW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt_r[SlotW-1:0]),
    .rdata (mem_rdata)
  );

  assign rd          = entry_t'(mem_rdata);
  assign issue       = (cnt_r < CntW'(Slots));
  assign sweep_done  = !issue && !pend_r;
  assign decide_fire = !out_valid_r || out_ch.ready;
  assign cutoff      = highest_r - 64'(max_inflight_r);

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.done_frame  = res_r.done_frame;
  assign out_ch.done_time   = res_r.done_time;
  assign out_ch.is_keyframe = res_r.is_keyframe;
  assign out_ch.done_codec  = res_r.done_codec;

  always_comb begin
    invalid = (item_r.fragment_count == 7'd0) ||
              (item_r.fragment_count > 7'(MaxFragments)) ||
              ({1'b0, item_r.fragment_index} >= item_r.fragment_count);
    hi_id = (item_r.frame_id > highest_r) ? item_r.frame_id : highest_r;
    dec_slot = found_r ? hit_idx_r : (free_found_r ? free_idx_r : min_idx_r);
    bitv = PresOne << item_r.fragment_index;
    if (found_r) begin
      base = hit_r;
    end else begin
      base.frame    = item_r.frame_id;
      base.total    = item_r.fragment_count;
      base.flags    = item_r.frame_flags;
      base.codec    = item_r.codec_id;
      base.dtime    = item_r.display_time;
      base.presence = '0;
      base.received = 7'd0;
    end
    upd          = base;
    upd.flags    = base.flags | item_r.frame_flags;
    upd.presence = base.presence | bitv;
    upd.received = base.received + 7'd1;
  end

  always_comb begin
    item_nxt       = item_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    highest_nxt    = highest_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    min_vld_nxt    = min_vld_r;
    min_frame_nxt  = min_frame_r;
    min_idx_nxt    = min_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = dec_slot;
    mem_wdata      = upd;
    evict_go       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.frame_id       = in_ch.frame_id;
          item_nxt.fragment_index = in_ch.fragment_index;
          item_nxt.fragment_count = in_ch.fragment_count;
          item_nxt.frame_flags    = in_ch.frame_flags;
          item_nxt.codec_id       = in_ch.codec_id;
          item_nxt.display_time   = in_ch.display_time;
          cnt_nxt                 = '0;
          pend_nxt                = 1'b0;
          found_nxt               = 1'b0;
          free_found_nxt          = 1'b0;
          min_vld_nxt             = 1'b0;
        end
      end
      ST_SEARCH: begin
        pend_nxt = issue;
        pidx_nxt = cnt_r[SlotW-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + CntW'(1);
        end
        if (pend_r) begin
          if (valid_r[pidx_r]) begin
            if (!found_r && rd.frame == item_r.frame_id) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = pidx_r;
              hit_nxt     = rd;
            end
            if (!min_vld_r || rd.frame < min_frame_r) begin
              min_vld_nxt   = 1'b1;
              min_frame_nxt = rd.frame;
              min_idx_nxt   = pidx_r;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pidx_r;
          end
        end
      end
      ST_DECIDE: begin
        if (decide_fire) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          cnt_nxt       = '0;
          pend_nxt      = 1'b0;
          if (invalid) begin
            res_nxt.status = STAT_INVALID;
          end else begin
            highest_nxt = hi_id;
            if (base.total != item_r.fragment_count) begin
              res_nxt.status = STAT_MISMATCH;
            end else if ((base.presence & bitv) != '0) begin
              res_nxt.status = STAT_DUPLICATE;
            end else begin
              mem_we   = 1'b1;
              evict_go = (hi_id > 64'(max_inflight_r));
              if (upd.received == upd.total) begin
                res_nxt.status      = STAT_COMPLETE;
                res_nxt.done_frame  = item_r.frame_id;
                res_nxt.done_time   = base.dtime;
                res_nxt.is_keyframe = |(upd.flags & keyframe_mask_r);
                res_nxt.done_codec  = base.codec;
                valid_nxt[dec_slot] = 1'b0;
              end else begin
                res_nxt.status      = STAT_STORED;
                valid_nxt[dec_slot] = 1'b1;
              end
            end
          end
        end
      end
      ST_EVICT: begin
        pend_nxt = issue;
        pidx_nxt = cnt_r[SlotW-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + CntW'(1);
        end
        if (pend_r && valid_r[pidx_r] && rd.frame < cutoff) begin
          valid_nxt[pidx_r] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sweep_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (decide_fire) begin
          state_nxt = evict_go ? ST_EVICT : ST_IDLE;
        end
      end
      ST_EVICT: begin
        if (sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      highest_r       <= '0;
      valid_r         <= '0;
      max_inflight_r  <= 4'd8;
      keyframe_mask_r <= 16'd1;
      cnt_r           <= '0;
      pend_r          <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      highest_r   <= highest_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_MAX_INFLIGHT:  max_inflight_r  <= cfg_ch.data[3:0];
          REG_KEYFRAME_MASK: keyframe_mask_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    res_r        <= res_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    min_vld_r    <= min_vld_nxt;
    min_frame_r  <= min_frame_nxt;
    min_idx_r    <= min_idx_nxt;
  end

endmodule
